// File: sv/jsl_pkg.sv
// ----------------------------------------------------------------------------
// jsl_pkg: shared types and constants for the JPEG segment locator
// Beat payloads, parser phases, status codes and JPEG marker codes.
// ----------------------------------------------------------------------------
`default_nettype none

package jsl_pkg;

    // Width of the internal byte position counter (wraps modulo 2^OFFSET_BITS)
    localparam int OFFSET_BITS = 24;
    localparam int OUT_BITS    = 24;

    // Marker framing and codes
    localparam logic [7:0] MK_FILL = 8'hFF;
    localparam logic [7:0] MK_SOI  = 8'hD8;
    localparam logic [7:0] MK_EOI  = 8'hD9;
    localparam logic [7:0] MK_SOS  = 8'hDA;
    localparam logic [7:0] MK_DQT  = 8'hDB;
    localparam logic [7:0] MK_APP0 = 8'hE0;
    localparam logic [7:0] MK_DHT  = 8'hC4;
    localparam logic [7:0] MK_SOF0 = 8'hC0;

    // Table values start this many bytes past the byte after the DQT code
    localparam int TABLE_LEAD = 3;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FRAME_ERR = 2'd1;
    localparam logic [1:0] ST_NO_START  = 2'd2;
    localparam logic [1:0] ST_NO_EOI    = 2'd3;

    typedef enum logic [3:0] {
        PH_FRAME     = 4'd0,
        PH_CODE      = 4'd1,
        PH_LEN_HI    = 4'd2,
        PH_LEN_LO    = 4'd3,
        PH_SKIP      = 4'd4,
        PH_SOS_HI    = 4'd5,
        PH_SOS_LO    = 4'd6,
        PH_SOS_SKIP  = 4'd7,
        PH_SCAN      = 4'd8,
        PH_OK        = 4'd9,
        PH_BAD_FRAME = 4'd10,
        PH_BAD_START = 4'd11
    } jsl_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } jsl_in_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [1:0]          tables_found;
        logic [OUT_BITS-1:0] first_table_offset;
        logic [OUT_BITS-1:0] second_table_offset;
        logic [OUT_BITS-1:0] scan_offset;
        logic [OUT_BITS-1:0] scan_length;
    } jsl_out_t;

    // Fit a position onto the output width (zero-extend or cut)
    function automatic logic [OUT_BITS-1:0] to_out(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+OUT_BITS-1:0] wide;
        wide = {{OUT_BITS{1'b0}}, v};
        return wide[OUT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/jpeg_segment_locator.sv
// ----------------------------------------------------------------------------
// jpeg_segment_locator: JPEG marker segment locator, top level
// Walk the marker segments of one frame, one byte beat per cycle unless a last
// byte stalls, and report status, quantization table offsets and the scan extent.
// ----------------------------------------------------------------------------
// Usage:
//   byte channel   (byte_valid / byte_ready / byte_data): one frame byte per
//                  beat, last_byte set on the final byte of the frame.
//   result channel (result_valid / result_ready / result_data): one beat per
//                  frame, produced by the beat that carries last_byte.
// Throughput: one byte per cycle, except that a last byte waits while the
//   result register holds an untaken result. The segment state update is a
//   single short step between the input register and the result register;
//   a last byte is held in the input register, its result in the result register.
// Stall: the result register holds its beat while result_ready is low; the
//   input register keeps taking bytes that produce no result, and only a
//   second last byte waits for the result register to drain.
// Reset: rst_n clears the valid flags and the parser state; the block then
//   expects the FF of SOI. After every last byte the parser rearms for the next frame.
// ----------------------------------------------------------------------------
`default_nettype none

module jpeg_segment_locator
    import jsl_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    byte_valid,
    output logic         byte_ready,
    input  wire jsl_in_t byte_data,
    output logic         result_valid,
    input  wire logic    result_ready,
    output jsl_out_t     result_data
);

    logic     s1_valid;
    jsl_in_t  s1_item;
    logic     s1_adv;
    logic     res_fire;
    jsl_out_t res_item;

    logic     out_valid_reg;
    logic     out_valid_next;
    jsl_out_t out_item_reg;

    // Advance the held byte unless it makes a result and the result register
    // still holds one that is not being taken
    assign s1_adv     = s1_valid
                     && (!s1_item.last_byte || !out_valid_reg || result_ready);
    assign byte_ready = !s1_valid || s1_adv;
    assign res_fire   = s1_adv && s1_item.last_byte;

    jsl_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (byte_valid && byte_ready),
        .load_item   (byte_data),
        .advance     (s1_adv),
        .stage_valid (s1_valid),
        .stage_item  (s1_item)
    );

    jsl_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_adv),
        .item   (s1_item),
        .result (res_item)
    );

    // Result register: load on a last byte, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            out_item_reg <= res_item;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_item_reg;

    // A new result must never land on an untaken one
    assert property (@(posedge clk) disable iff (!rst_n)
        !(res_fire && out_valid_reg && !result_ready))
        else $error("result register overwritten");

    // Every new result beat comes from a last byte taken by the parser in the cycle before
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !$past(result_valid && !result_ready)) |-> $past(res_fire))
        else $error("result without a last byte");

    // A stalled result holds its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result_data)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// File: sv/jsl_in_stage.sv
// ----------------------------------------------------------------------------
// jsl_in_stage: input register
// Capture one byte beat and hold it until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module jsl_in_stage
    import jsl_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire jsl_in_t load_item,
    input  wire logic    advance,
    output logic         stage_valid,
    output jsl_in_t      stage_item
);

    logic    valid_reg;
    logic    valid_next;
    jsl_in_t item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    // A held beat that is not taken must not change
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !advance) |=> (valid_reg && $stable(item_reg)))
        else $error("input stage lost or changed a held beat");

    // Never load over a beat that is not leaving
    assert property (@(posedge clk) disable iff (!rst_n)
        !(load && valid_reg && !advance))
        else $error("input stage overwritten");

endmodule

`default_nettype wire

// File: sv/jsl_parser.sv
// ----------------------------------------------------------------------------
// jsl_parser: marker segment walker
// Step the segment state by one byte; form the frame result on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module jsl_parser
    import jsl_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step,
    input  wire jsl_in_t item,
    output jsl_out_t     result
);

    localparam logic [OFFSET_BITS-1:0] POS_ONE  = OFFSET_BITS'(1);
    localparam logic [OFFSET_BITS-1:0] POS_LEAD = OFFSET_BITS'(TABLE_LEAD + 1);

    jsl_phase_t             phase_reg,  phase_next,  phase_u;
    logic [OFFSET_BITS-1:0] pos_reg,    pos_next,    pos_u;
    logic [15:0]            skip_reg,   skip_next,   skip_u;
    logic [7:0]             len_hi_reg, len_hi_next, len_hi_u;
    logic                   saw_ff_reg, saw_ff_next, saw_ff_u;
    logic                   start_reg,  start_next,  start_u;
    logic [1:0]             tcnt_reg,   tcnt_next,   tcnt_u;
    logic [OFFSET_BITS-1:0] t1_reg,     t1_next,     t1_u;
    logic [OFFSET_BITS-1:0] t2_reg,     t2_next,     t2_u;
    logic [OFFSET_BITS-1:0] scan_reg,   scan_next,   scan_u;

    logic [7:0]             b;
    logic [15:0]            seg_len;
    logic [15:0]            skip_dec;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [OFFSET_BITS-1:0] table_at;
    logic [OFFSET_BITS-1:0] scan_len;
    logic                   settled_u;
    logic [1:0]             status;

    assign b        = item.data_byte;
    assign seg_len  = {len_hi_reg, b};
    assign skip_dec = skip_reg - 16'd1;
    assign pos_inc  = pos_reg + POS_ONE;
    assign table_at = pos_reg + POS_LEAD;
    assign scan_len = pos_reg - POS_ONE - scan_reg;

    // Phase transition for one byte
    always_comb
    begin
        phase_u  = phase_reg;
        skip_u   = skip_reg;
        len_hi_u = len_hi_reg;
        saw_ff_u = saw_ff_reg;
        start_u  = start_reg;
        tcnt_u   = tcnt_reg;
        t1_u     = t1_reg;
        t2_u     = t2_reg;
        scan_u   = scan_reg;

        unique case (phase_reg) inside
            PH_FRAME:
            begin
                phase_u = (b == MK_FILL) ? PH_CODE : PH_BAD_FRAME;
            end
            PH_CODE:
            begin
                if (b == MK_FILL)
                begin
                    phase_u = PH_CODE;
                end
                else if (b == MK_SOI)
                begin
                    start_u = 1'b1;
                    phase_u = PH_FRAME;
                end
                else if (b == MK_SOS)
                begin
                    phase_u = start_reg ? PH_SOS_HI : PH_BAD_START;
                end
                else if (b == MK_DQT)
                begin
                    if (tcnt_reg == 2'd0)
                    begin
                        t1_u   = table_at;
                        tcnt_u = 2'd1;
                    end
                    else if (tcnt_reg == 2'd1)
                    begin
                        t2_u   = table_at;
                        tcnt_u = 2'd2;
                    end
                    phase_u = PH_LEN_HI;
                end
                else if (b == MK_APP0 || b == MK_DHT || b == MK_SOF0)
                begin
                    phase_u = PH_LEN_HI;
                end
                else
                begin
                    phase_u = PH_FRAME;
                end
            end
            PH_LEN_HI, PH_SOS_HI:
            begin
                len_hi_u = b;
                phase_u  = (phase_reg == PH_LEN_HI) ? PH_LEN_LO : PH_SOS_LO;
            end
            PH_LEN_LO, PH_SOS_LO:
            begin
                if (seg_len < 16'd2)
                begin
                    phase_u = PH_BAD_FRAME;
                end
                else
                begin
                    skip_u = seg_len - 16'd2;
                    if (seg_len != 16'd2)
                    begin
                        phase_u = (phase_reg == PH_LEN_LO) ? PH_SKIP : PH_SOS_SKIP;
                    end
                    else if (phase_reg == PH_LEN_LO)
                    begin
                        phase_u = PH_FRAME;
                    end
                    else
                    begin
                        phase_u  = PH_SCAN;
                        scan_u   = pos_inc;
                        saw_ff_u = 1'b0;
                    end
                end
            end
            PH_SKIP, PH_SOS_SKIP:
            begin
                skip_u = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    if (phase_reg == PH_SKIP)
                    begin
                        phase_u = PH_FRAME;
                    end
                    else
                    begin
                        phase_u  = PH_SCAN;
                        scan_u   = pos_inc;
                        saw_ff_u = 1'b0;
                    end
                end
            end
            PH_SCAN:
            begin
                // any run of fill bytes before D9 ends the scan
                if (saw_ff_reg && b == MK_EOI)
                begin
                    phase_u = PH_OK;
                end
                else
                begin
                    saw_ff_u = (b == MK_FILL);
                end
            end
            default:
            begin
                // outcome fixed: ignore the rest of the frame
                phase_u = phase_reg;
            end
        endcase

        settled_u = (phase_u == PH_OK) || (phase_u == PH_BAD_FRAME)
                 || (phase_u == PH_BAD_START);
        // freeze the position once the outcome is fixed
        pos_u = settled_u ? pos_reg : pos_inc;
    end

    // Result formed from the state after this byte
    always_comb
    begin
        unique case (phase_u)
            PH_OK:        status = ST_OK;
            PH_BAD_FRAME: status = ST_FRAME_ERR;
            PH_SCAN:      status = ST_NO_EOI;
            default:      status = ST_NO_START;
        endcase

        result.status              = status;
        result.tables_found        = tcnt_u;
        result.first_table_offset  = to_out(t1_u);
        result.second_table_offset = to_out(t2_u);
        result.scan_offset         = (status == ST_OK || status == ST_NO_EOI)
                                   ? to_out(scan_u) : '0;
        result.scan_length         = (status == ST_OK) ? to_out(scan_len) : '0;
    end

    // Advance on a step; rearm for the next frame after the last byte
    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        skip_next   = skip_reg;
        len_hi_next = len_hi_reg;
        saw_ff_next = saw_ff_reg;
        start_next  = start_reg;
        tcnt_next   = tcnt_reg;
        t1_next     = t1_reg;
        t2_next     = t2_reg;
        scan_next   = scan_reg;
        if (step && item.last_byte)
        begin
            phase_next  = PH_FRAME;
            pos_next    = '0;
            skip_next   = '0;
            len_hi_next = '0;
            saw_ff_next = 1'b0;
            start_next  = 1'b0;
            tcnt_next   = '0;
            t1_next     = '0;
            t2_next     = '0;
            scan_next   = '0;
        end
        else if (step)
        begin
            phase_next  = phase_u;
            pos_next    = pos_u;
            skip_next   = skip_u;
            len_hi_next = len_hi_u;
            saw_ff_next = saw_ff_u;
            start_next  = start_u;
            tcnt_next   = tcnt_u;
            t1_next     = t1_u;
            t2_next     = t2_u;
            scan_next   = scan_u;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FRAME;
            pos_reg    <= '0;
            skip_reg   <= '0;
            len_hi_reg <= '0;
            saw_ff_reg <= 1'b0;
            start_reg  <= 1'b0;
            tcnt_reg   <= '0;
            t1_reg     <= '0;
            t2_reg     <= '0;
            scan_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            skip_reg   <= skip_next;
            len_hi_reg <= len_hi_next;
            saw_ff_reg <= saw_ff_next;
            start_reg  <= start_next;
            tcnt_reg   <= tcnt_next;
            t1_reg     <= t1_next;
            t2_reg     <= t2_next;
            scan_reg   <= scan_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        tcnt_reg != 2'd3)
        else $error("table count overran");

    assert property (@(posedge clk) disable iff (!rst_n)
        (tcnt_reg != 2'd2) |-> (t2_reg == '0))
        else $error("second table offset set without two tables");

    assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PH_OK || phase_reg == PH_BAD_FRAME || phase_reg == PH_BAD_START)
         && !(step && item.last_byte)) |=> $stable(pos_reg))
        else $error("position moved after the outcome was fixed");

endmodule

`default_nettype wire
